// File: rtl/core/bgf_pkg.sv
package bgf_pkg;

	localparam int DIM_W       = 10;
	localparam int COLOR_W     = 16;
	localparam int COORD_W     = 11;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int CHAN_W      = 6;
	localparam int T_W         = 8;
	localparam int DEF_MAX_DIM = 1024;

	localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LEFT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_WIDTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_HEIGHT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_LERP,
		ST_EMIT
	} fill_state_t;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} chan_t;

	typedef enum logic {
		PH_ROW,
		PH_PIX
	} phase_t;

	function automatic logic [CHAN_W-1:0] get_chan(input logic [COLOR_W-1:0] c, input chan_t ch);
		logic [CHAN_W-1:0] v;
		case (ch)
			CH_RED:   v = {1'b0, c[15:11]};
			CH_GREEN: v = c[10:5];
			CH_BLUE:  v = {1'b0, c[4:0]};
			default:  v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [COLOR_W-1:0] put_chan(input logic [COLOR_W-1:0] c, input chan_t ch,
		input logic [CHAN_W-1:0] v);
		logic [COLOR_W-1:0] r;
		r = c;
		case (ch)
			CH_RED:   r[15:11] = v[4:0];
			CH_GREEN: r[10:5]  = v;
			CH_BLUE:  r[4:0]   = v[4:0];
			default:  r = c;
		endcase
		return r;
	endfunction

	// a + trunc((b - a) * t / 255); |d|*t < 2^16, so /255 is (x + (x>>8) + 1) >> 8
	function automatic logic [CHAN_W-1:0] lerp_chan(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b, input logic [T_W-1:0] t);
		logic signed [CHAN_W:0] d;
		logic [CHAN_W-1:0] mag;
		logic [13:0] prod;
		logic [14:0] sum;
		logic [CHAN_W-1:0] q;
		d    = $signed({1'b0, b}) - $signed({1'b0, a});
		mag  = d[CHAN_W] ? CHAN_W'(-d) : d[CHAN_W-1:0];
		prod = 14'(mag) * 14'(t);
		sum  = 15'(prod) + 15'(prod >> 8) + 15'd1;
		q    = CHAN_W'(sum >> 8);
		return d[CHAN_W] ? a - q : a + q;
	endfunction

endpackage

// File: rtl/core/bilinear_gradient_fill.sv
// Channel   Handshake                 Payload
// input     in_valid / in_ready       restart
// output    out_valid / out_ready     pixel_x, pixel_y, pixel_color, last_pixel
// config    cfg_we                    cfg_index, cfg_data
//
// Each pixel uses 9 steps of the shared compare-subtract divider for
// the column weight, 3 passes of the channel lerp unit, and a load of the output.
// A row start adds the divider for the row weight and 6 lerp passes, on restart
// before the first pixel and otherwise after the row's last pixel.
// Reset clears the control, edge and configuration registers; the block is idle.
// in_ready is low while an item is at work; a stalled output holds the block in ST_EMIT.
module bilinear_gradient_fill import bgf_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_W-1:0]    pixel_x,
	output logic [COORD_W-1:0]    pixel_y,
	output logic [COLOR_W-1:0]    pixel_color,
	output logic                  last_pixel
);

	localparam int DIM_MAX = (1 << DIM_W) - 1;
	localparam int LIM     = (MAX_DIM - 1 < DIM_MAX) ? MAX_DIM - 1 : DIM_MAX;
	localparam int IDX_W   = ($clog2(MAX_DIM) < DIM_W) ? $clog2(MAX_DIM) : DIM_W;
	localparam int NUM_W   = DIM_W + T_W;
	localparam int STEP_W  = $clog2(T_W + 1);

	logic [COLOR_W-1:0] tl_q, tr_q, bl_q, br_q;
	logic [DIM_W-1:0]   width_q, height_q, ox_q, oy_q;

	fill_state_t state_q, state_d;
	phase_t      phase_q, load_phase;
	chan_t       ch_q;
	logic        active_q, rowsel_q, after_emit_q, out_valid_q;
	logic [IDX_W-1:0]  col_q, row_q;
	logic [STEP_W-1:0] step_q;
	logic [COLOR_W-1:0] left_q, right_q, pix_q;

	logic [NUM_W-1:0]  rem_q;
	logic [DIM_W-1:0]  div_q;
	logic [T_W-1:0]    quo_q;
	logic              sat_q, zero_q;

	logic [COORD_W-1:0] px_q, py_q;
	logic [COLOR_W-1:0] pc_q;
	logic               last_q;

	logic [DIM_W-1:0] w_c, h_c, col_ext, row_ext, div_idx, div_dim;
	logic             in_fire, out_fire, dims_ok, row_end, last_c, emit_ok, lerp_done;
	logic             load_div, ge;
	logic [NUM_W-1:0] num_c, dsh;
	logic [T_W-1:0]   t_c;
	logic [COLOR_W-1:0] src_a, src_b;
	logic [CHAN_W-1:0]  chan_val;

	assign w_c      = (width_q > DIM_W'(LIM)) ? DIM_W'(LIM) : width_q;
	assign h_c      = (height_q > DIM_W'(LIM)) ? DIM_W'(LIM) : height_q;
	assign dims_ok  = (w_c != '0) && (h_c != '0);
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;
	assign col_ext  = DIM_W'(col_q);
	assign row_ext  = DIM_W'(row_q);
	assign row_end  = ((DIM_W+1)'(col_ext) + (DIM_W+1)'(1)) >= (DIM_W+1)'(w_c);
	assign last_c   = row_end && (((DIM_W+1)'(row_ext) + (DIM_W+1)'(1)) >= (DIM_W+1)'(h_c));
	assign emit_ok  = !out_valid_q || out_ready;

	assign num_c = (NUM_W'(div_idx) << T_W) - NUM_W'(div_idx);
	assign dsh   = NUM_W'(div_q) << step_q;
	assign ge    = rem_q >= dsh;
	assign t_c   = zero_q ? '0 : (sat_q ? {T_W{1'b1}} : quo_q);

	always_comb begin
		if (phase_q == PH_PIX) begin
			src_a = left_q;
			src_b = right_q;
		end else if (!rowsel_q) begin
			src_a = tl_q;
			src_b = bl_q;
		end else begin
			src_a = tr_q;
			src_b = br_q;
		end
	end

	assign chan_val  = lerp_chan(get_chan(src_a, ch_q), get_chan(src_b, ch_q), t_c);
	assign lerp_done = (ch_q == CH_BLUE) && ((phase_q == PH_PIX) || rowsel_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && (restart ? dims_ok : active_q))
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (step_q == '0)
					state_d = ST_LERP;
			end
			ST_LERP: begin
				if (lerp_done) begin
					if (phase_q == PH_PIX)
						state_d = ST_EMIT;
					else if (after_emit_q)
						state_d = ST_IDLE;
					else
						state_d = ST_DIV;
				end
			end
			ST_EMIT: begin
				if (emit_ok)
					state_d = (row_end && !last_c) ? ST_DIV : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		load_div   = 1'b0;
		load_phase = PH_PIX;
		div_idx    = col_ext;
		div_dim    = w_c;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				load_div = in_fire && (restart ? dims_ok : active_q);
				if (restart) begin
					load_phase = PH_ROW;
					div_idx    = '0;
					div_dim    = h_c;
				end
			end
			ST_LERP: begin
				load_div = lerp_done && (phase_q == PH_ROW) && !after_emit_q;
			end
			ST_EMIT: begin
				load_div   = emit_ok && row_end && !last_c;
				load_phase = PH_ROW;
				div_idx    = row_ext + DIM_W'(1);
				div_dim    = h_c;
			end
			default: begin
				load_div = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q         <= '0;
			tr_q         <= '0;
			bl_q         <= '0;
			br_q         <= '0;
			width_q      <= '0;
			height_q     <= '0;
			ox_q         <= '0;
			oy_q         <= '0;
			state_q      <= ST_IDLE;
			phase_q      <= PH_ROW;
			ch_q         <= CH_RED;
			active_q     <= 1'b0;
			rowsel_q     <= 1'b0;
			after_emit_q <= 1'b0;
			out_valid_q  <= 1'b0;
			col_q        <= '0;
			row_q        <= '0;
			step_q       <= '0;
			left_q       <= '0;
			right_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_TOP_LEFT:     tl_q     <= cfg_data;
					REG_TOP_RIGHT:    tr_q     <= cfg_data;
					REG_BOTTOM_LEFT:  bl_q     <= cfg_data;
					REG_BOTTOM_RIGHT: br_q     <= cfg_data;
					REG_FILL_WIDTH:   width_q  <= cfg_data[DIM_W-1:0];
					REG_FILL_HEIGHT:  height_q <= cfg_data[DIM_W-1:0];
					REG_ORIGIN_X:     ox_q     <= cfg_data[DIM_W-1:0];
					REG_ORIGIN_Y:     oy_q     <= cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && in_fire && restart) begin
				col_q        <= '0;
				row_q        <= '0;
				active_q     <= dims_ok;
				after_emit_q <= 1'b0;
			end
			if (load_div) begin
				phase_q <= load_phase;
				step_q  <= STEP_W'(T_W);
			end else if (state_q == ST_DIV && step_q != '0) begin
				step_q <= step_q - STEP_W'(1);
			end
			if (state_q == ST_DIV && step_q == '0) begin
				ch_q     <= CH_RED;
				rowsel_q <= 1'b0;
			end
			if (state_q == ST_LERP) begin
				if (phase_q == PH_ROW) begin
					if (!rowsel_q)
						left_q <= put_chan(left_q, ch_q, chan_val);
					else
						right_q <= put_chan(right_q, ch_q, chan_val);
				end
				case (ch_q)
					CH_RED:   ch_q <= CH_GREEN;
					CH_GREEN: ch_q <= CH_BLUE;
					default: begin
						ch_q     <= CH_RED;
						rowsel_q <= 1'b1;
					end
				endcase
			end
			if (state_q == ST_EMIT && emit_ok) begin
				out_valid_q  <= 1'b1;
				after_emit_q <= 1'b1;
				if (last_c) begin
					active_q <= 1'b0;
					col_q    <= '0;
					row_q    <= '0;
				end else if (row_end) begin
					col_q <= '0;
					row_q <= row_q + IDX_W'(1);
				end else begin
					col_q <= col_q + IDX_W'(1);
				end
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_div) begin
			rem_q  <= num_c;
			div_q  <= div_dim - DIM_W'(1);
			zero_q <= div_dim <= DIM_W'(1);
			sat_q  <= 1'b0;
			quo_q  <= '0;
		end else if (state_q == ST_DIV) begin
			if (step_q == STEP_W'(T_W)) begin
				sat_q <= ge;
			end else begin
				if (ge)
					rem_q <= rem_q - dsh;
				quo_q <= {quo_q[T_W-2:0], ge};
			end
		end
		if (state_q == ST_LERP && phase_q == PH_PIX)
			pix_q <= put_chan(pix_q, ch_q, chan_val);
		if (state_q == ST_EMIT && emit_ok) begin
			px_q   <= COORD_W'(ox_q) + COORD_W'(col_ext);
			py_q   <= COORD_W'(oy_q) + COORD_W'(row_ext);
			pc_q   <= pix_q;
			last_q <= last_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_color = pc_q;
	assign last_pixel  = last_q;

endmodule

// File: rtl/core/bgf_checker.sv
module bgf_checker import bgf_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COORD_W-1:0] pixel_x,
	input logic [COORD_W-1:0] pixel_y,
	input logic [COLOR_W-1:0] pixel_color,
	input logic               last_pixel
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(pixel_color) && $stable(last_pixel))
		else $error("output changed while stalled");

	// the block goes busy only on an input transfer
	a_busy_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid) && $past(in_ready))
		else $error("in_ready dropped without a transfer");

	// a new result is produced only while busy
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

endmodule

bind bilinear_gradient_fill bgf_checker u_bgf_checker (.*);
